// ----- rtl/mme_pkg.sv -----
// ---------------------------------------------------------------------------
// mme_pkg
// Shared widths, codes and types of the matrix multiply engine.
// ---------------------------------------------------------------------------
package mme_pkg;

	localparam int SIZE_W    = 5;
	localparam int IDX_W     = 4;
	localparam int ELEM_W    = 16;
	localparam int PROD_W    = 2 * ELEM_W;
	localparam int SUM_W     = 40;
	localparam int KIND_W    = 2;
	localparam int CFG_IDX_W = 2;

	localparam int DEF_MAX_ROWS  = 16;
	localparam int DEF_MAX_INNER = 16;
	localparam int DEF_MAX_COLS  = 16;

	localparam logic [KIND_W-1:0] KIND_LOAD_A = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD_B = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_USED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_USED  = 2'd2;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic [IDX_W-1:0]         row_index;
		logic [IDX_W-1:0]         col_index;
		logic signed [ELEM_W-1:0] element_value;
	} req_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] product_value;
		logic                    index_error;
	} res_t;

	typedef struct packed {
		logic [SIZE_W-1:0] nr;
		logic [SIZE_W-1:0] ni;
		logic [SIZE_W-1:0] nc;
	} sizes_t;

	typedef struct packed {
		logic load_a;
		logic load_b;
		logic q_start;
		logic issue;
		logic finish;
		logic finish_imm;
		logic imm_err;
	} cmd_t;

	typedef struct packed {
		logic q_in_range;
		logic ni_zero;
		logic last_k;
		logic pipe_busy;
	} sts_t;

endpackage

// ----- rtl/mme_ctrl.sv -----
// ---------------------------------------------------------------------------
// mme_ctrl
// Request sequencer: dispatches loads, runs the inner-product loop of a
// query and drains the multiply-accumulate pipeline.
// ---------------------------------------------------------------------------
module mme_ctrl import mme_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [KIND_W-1:0] kind,
	input  sts_t              sts,
	output logic              busy,
	output cmd_t              cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (kind)
						KIND_LOAD_A: cmd.load_a = 1'b1;
						KIND_LOAD_B: cmd.load_b = 1'b1;
						KIND_QUERY: begin
							if (!sts.q_in_range) begin
								cmd.finish_imm = 1'b1;
								cmd.imm_err    = 1'b1;
							end else if (sts.ni_zero) begin
								cmd.finish_imm = 1'b1;
							end else begin
								cmd.q_start = 1'b1;
								state_d     = ST_RUN;
							end
						end
						default: ;
					endcase
				end
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
				if (sts.last_k) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ----- rtl/mme_dpath.sv -----
// ---------------------------------------------------------------------------
// mme_dpath
// Element stores for A and B, read counter, multiply-accumulate pipeline
// and result register.
// ---------------------------------------------------------------------------
module mme_dpath import mme_pkg::*; #(
	parameter int MAX_ROWS  = DEF_MAX_ROWS,
	parameter int MAX_INNER = DEF_MAX_INNER,
	parameter int MAX_COLS  = DEF_MAX_COLS
) (
	input  logic   clk,
	input  logic   arst_n,
	input  req_t   request,
	input  sizes_t sizes,
	input  cmd_t   cmd,
	output sts_t   sts,
	output logic   done,
	output res_t   result
);

	localparam int A_DEPTH     = MAX_ROWS * MAX_INNER;
	localparam int B_DEPTH     = MAX_INNER * MAX_COLS;
	localparam int A_AW        = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
	localparam int B_AW        = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
	localparam int K_W         = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
	localparam int ADDR_FULL_W = 17;
	localparam int CMP_W       = (K_W > SIZE_W) ? K_W : SIZE_W;

	logic [ELEM_W-1:0] a_mem [A_DEPTH];
	logic [ELEM_W-1:0] b_mem [B_DEPTH];

	logic [IDX_W-1:0]         row_q;
	logic [IDX_W-1:0]         col_q;
	logic [K_W-1:0]           k_q;
	logic                     v_s1;
	logic                     v_s2;
	logic signed [ELEM_W-1:0] a_rd_s1;
	logic signed [ELEM_W-1:0] b_rd_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [SUM_W-1:0]  acc_q;
	logic                     done_q;
	res_t                     res_q;

	logic [ADDR_FULL_W-1:0] a_wfull;
	logic [ADDR_FULL_W-1:0] b_wfull;
	logic [ADDR_FULL_W-1:0] a_rfull;
	logic [ADDR_FULL_W-1:0] b_rfull;
	logic [SIZE_W-1:0]      row_ext;
	logic [SIZE_W-1:0]      col_ext;
	logic                   a_wr_ok;
	logic                   b_wr_ok;

	assign row_ext = SIZE_W'(request.row_index);
	assign col_ext = SIZE_W'(request.col_index);
	assign a_wr_ok = (row_ext < sizes.nr) && (col_ext < sizes.ni);
	assign b_wr_ok = (row_ext < sizes.ni) && (col_ext < sizes.nc);

	assign a_wfull = ADDR_FULL_W'(request.row_index) * ADDR_FULL_W'(MAX_INNER)
		+ ADDR_FULL_W'(request.col_index);
	assign b_wfull = ADDR_FULL_W'(request.row_index) * ADDR_FULL_W'(MAX_COLS)
		+ ADDR_FULL_W'(request.col_index);
	assign a_rfull = ADDR_FULL_W'(row_q) * ADDR_FULL_W'(MAX_INNER) + ADDR_FULL_W'(k_q);
	assign b_rfull = ADDR_FULL_W'(k_q) * ADDR_FULL_W'(MAX_COLS) + ADDR_FULL_W'(col_q);

	assign sts.q_in_range = (row_ext < sizes.nr) && (col_ext < sizes.nc);
	assign sts.ni_zero    = (sizes.ni == '0);
	assign sts.last_k     = (CMP_W'(k_q) == CMP_W'(sizes.ni - 1'b1));
	assign sts.pipe_busy  = v_s1 | v_s2;

	always_ff @(posedge clk) begin
		if (cmd.load_a && a_wr_ok) begin
			a_mem[a_wfull[A_AW-1:0]] <= request.element_value;
		end
		a_rd_s1 <= a_mem[a_rfull[A_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_b && b_wr_ok) begin
			b_mem[b_wfull[B_AW-1:0]] <= request.element_value;
		end
		b_rd_s1 <= b_mem[b_rfull[B_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.q_start) begin
			row_q <= request.row_index;
			col_q <= request.col_index;
		end
		prod_s2 <= a_rd_s1 * b_rd_s1;
		if (cmd.q_start) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + SUM_W'(prod_s2);
		end
		if (cmd.finish) begin
			res_q.product_value <= acc_q;
			res_q.index_error   <= 1'b0;
		end else if (cmd.finish_imm) begin
			res_q.product_value <= '0;
			res_q.index_error   <= cmd.imm_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (cmd.q_start) begin
				k_q <= '0;
			end else if (cmd.issue) begin
				k_q <= k_q + 1'b1;
			end
			v_s1   <= cmd.issue;
			v_s2   <= v_s1;
			done_q <= cmd.finish | cmd.finish_imm;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ----- rtl/matrix_multiply_engine.sv -----
// ---------------------------------------------------------------------------
// matrix_multiply_engine
// Dense fixed-point matrix multiply C = A x B with element-wise loads and
// element-wise queries of C.
// Loads are accepted back to back; they produce no result.
// A query in range makes one MAC pass per inner index through a single
// 16x16 multiplier and its 2-deep read/multiply pipeline; busy stays high
// until that pipeline drains and falls in the cycle that done strobes, and
// no new request is taken while busy is high.
// An out-of-range query, or one with inner size zero, answers the next cycle.
// arst_n sets all sizes to 16 and idles the sequencer; stores are not cleared.
// ---------------------------------------------------------------------------
module matrix_multiply_engine import mme_pkg::*; #(
	parameter int MAX_ROWS  = DEF_MAX_ROWS,
	parameter int MAX_INNER = DEF_MAX_INNER,
	parameter int MAX_COLS  = DEF_MAX_COLS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  req_t                 request,
	output logic                 done,
	output res_t                 result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_data
);

	logic [SIZE_W-1:0] rows_used_q;
	logic [SIZE_W-1:0] inner_used_q;
	logic [SIZE_W-1:0] cols_used_q;
	sizes_t            sizes;
	cmd_t              cmd;
	sts_t              sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_used_q  <= SIZE_RESET;
			inner_used_q <= SIZE_RESET;
			cols_used_q  <= SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROWS_USED:  rows_used_q  <= cfg_data;
				REG_INNER_USED: inner_used_q <= cfg_data;
				REG_COLS_USED:  cols_used_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// sizes saturate at the store dimensions
	assign sizes.nr = (32'(rows_used_q) > 32'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : rows_used_q;
	assign sizes.ni = (32'(inner_used_q) > 32'(MAX_INNER)) ? SIZE_W'(MAX_INNER) : inner_used_q;
	assign sizes.nc = (32'(cols_used_q) > 32'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : cols_used_q;

	mme_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (request.kind),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	mme_dpath #(
		.MAX_ROWS  (MAX_ROWS),
		.MAX_INNER (MAX_INNER),
		.MAX_COLS  (MAX_COLS)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.sizes   (sizes),
		.cmd     (cmd),
		.sts     (sts),
		.done    (done),
		.result  (result)
	);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while sequencer busy");

	a_query_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.kind == KIND_QUERY) |=> (busy || done))
		else $error("query request neither running nor answered");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (request.kind == KIND_LOAD_A || request.kind == KIND_LOAD_B))
		|=> !done)
		else $error("load request produced a result");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.index_error) |-> (result.product_value == '0))
		else $error("error result carries nonzero value");

endmodule
